// File: src/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine execute package
// Shared action codes, request struct and constants.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int StackDepthDefault = 64;
  localparam int PlenW = 15;
  localparam int DataW = 64;

  typedef enum logic [3:0] {
    ACT_PUSH = 4'd0,
    ACT_POP  = 4'd1,
    ACT_ADD  = 4'd2,
    ACT_SUB  = 4'd3,
    ACT_MUL  = 4'd4,
    ACT_DIV  = 4'd5,
    ACT_OUT  = 4'd6,
    ACT_JMP  = 4'd7,
    ACT_JE   = 4'd8,
    ACT_JNE  = 4'd9,
    ACT_JA   = 4'd10,
    ACT_JAE  = 4'd11,
    ACT_JB   = 4'd12,
    ACT_JBE  = 4'd13
  } action_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [3:0]       action;
    logic [DataW-1:0] operand;
    logic             target_ok;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_EXEC,
    ST_ARITH,
    ST_RESULT
  } state_t;

endpackage

// File: src/stack_machine_execute.sv
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Runs stack-machine instructions over a Q32.32 operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (action, operand) arrive on in_valid/in_stall; each gives
//   one result (ok, popped_value, jump_taken, jump_target) on out_valid /
//   out_stall. program_length is written through cfg_we/cfg_wdata, by the user
//   only while idle; the block itself does not enforce this. A front end
//   checks jump targets and places requests in a two-entry queue; the back
//   end executes them against a RAM-held stack. The divider makes one
//   quotient bit per cycle. The stack RAM has a single read port: one
//   operand read per cycle.
//   Reset empties the stack and clears program_length; stack contents are
//   not cleared. While out_stall is high the result holds, the back end
//   waits, and the queue fills before in_stall rises.
// ----------------------------------------------------------------------------
module stack_machine_execute
  import sme_pkg::*;
#(
  parameter int StackDepth = StackDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       action,
  input  logic [DataW-1:0] operand,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             ok,
  output logic [DataW-1:0] popped_value,
  output logic             jump_taken,
  output logic [PlenW-1:0] jump_target,
  input  logic             cfg_we,
  input  logic [PlenW-1:0] cfg_wdata
);
  logic [PlenW-1:0] program_length;
  logic             q_valid, q_pop;
  req_t             q_req;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_we) begin
      program_length <= cfg_wdata;
    end
  end

  sme_front u_front (
    .clk, .rst, .in_valid, .in_stall, .action, .operand, .program_length,
    .q_valid, .q_req, .q_pop
  );

  sme_back #(.StackDepth(StackDepth)) u_back (
    .clk, .rst, .q_valid, .q_req, .q_pop, .out_valid, .out_stall,
    .ok, .popped_value, .jump_taken, .jump_target
  );

  // a taken jump always reports success
  a_jump_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && jump_taken |-> ok) else $error("jump without ok");

  // popped value only on a successful request
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && popped_value != '0 |-> ok && !jump_taken)
    else $error("popped value on failure");

  // jump target zero when no jump
  a_tgt: assert property (@(posedge clk) disable iff (rst)
    out_valid && !jump_taken |-> jump_target == '0) else $error("stray target");
endmodule

// File: src/sme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/sme_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, checks jump targets, feeds a two-entry queue.
// ----------------------------------------------------------------------------
module sme_front
  import sme_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       action,
  input  logic [DataW-1:0] operand,
  input  logic [PlenW-1:0] program_length,
  output logic             q_valid,
  output req_t             q_req,
  input  logic             q_pop
);
  req_t       entry [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push;
  req_t       req_in;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    req_in.action    = action;
    req_in.operand   = operand;
    req_in.target_ok = !operand[DataW-1] &&
                       (operand[DataW-2:PlenW] == '0) &&
                       (operand[PlenW-1:0] < program_length);
  end

  assign q_valid = (count != 2'd0);
  assign q_req   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= req_in;
    end
    if (rst) begin
      count  <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// File: src/sme_divider.sv
// ----------------------------------------------------------------------------
// Q32.32 divider
// Restoring division of magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_divider
  import sme_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output logic             done,
  output logic [DataW-1:0] quotient,
  output logic             over
);
  logic [DataW:0]   rem;
  logic [DataW-1:0] num;
  logic [DataW-1:0] den;
  logic [6:0]       cnt;
  logic             busy;
  logic [DataW:0]   trial;
  logic [DataW:0]   rem_sh;

  assign rem_sh = {rem[DataW-1:0], (cnt >= 7'd32) ? num[DataW-1] : 1'b0};
  assign trial  = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
      over     <= 1'b0;
      cnt      <= 7'd95;
    end else if (busy) begin
      if (cnt >= 7'd32) num <= {num[DataW-2:0], 1'b0};
      if (quotient[DataW-1]) over <= 1'b1;
      if (!trial[DataW]) begin
        rem      <= trial;
        quotient <= {quotient[DataW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[DataW-2:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 7'd0);
      if (start) busy <= 1'b1;
      else if (cnt == 7'd0) busy <= 1'b0;
    end
  end
endmodule

// File: src/sme_back.sv
// ----------------------------------------------------------------------------
// Back end
// Executes queued requests against the operand stack.
// ----------------------------------------------------------------------------
module sme_back
  import sme_pkg::*;
#(
  parameter int StackDepth = StackDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  req_t             q_req,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             ok,
  output logic [DataW-1:0] popped_value,
  output logic             jump_taken,
  output logic [PlenW-1:0] jump_target
);
  localparam int AW = $clog2(StackDepth);
  localparam int CW = $clog2(StackDepth + 1);

  state_t state, state_next;
  req_t   cur;
  logic [CW-1:0]    cnt;
  logic [DataW-1:0] first, second, rdata;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;
  logic             sat_neg;

  // multiplier partial products
  logic [DataW-1:0] ma, mb, mag_res;
  logic [63:0]      pll, plh, phl, phh;
  logic [2:0]       mstep;
  logic             mul_over;

  logic             div_start, div_done, div_over;
  logic [DataW-1:0] div_q;

  logic [DataW-1:0] res_val;
  logic [DataW-1:0] sum, dif;
  logic             cond, lt, eq;
  logic             is_arith;

  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] x);
    mag = x[DataW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [DataW-1:0] apply_sign(input logic [DataW-1:0] m,
                                                  input logic neg, input logic ov);
    logic [DataW-1:0] mn;
    mn = {1'b1, {(DataW-1){1'b0}}};
    if (neg) apply_sign = (ov || m > mn) ? mn : (~m + 1'b1);
    else     apply_sign = (ov || m[DataW-1]) ? ~mn : m;
  endfunction

  sme_ram #(.Width(DataW), .Depth(StackDepth)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // operands are taken straight from the stack reads, start is in ST_EXEC
  sme_divider u_div (
    .clk, .rst, .start(div_start), .dividend(mag(first)), .divisor(mag(second)),
    .done(div_done), .quotient(div_q), .over(div_over)
  );

  assign is_arith = (cur.action <= ACT_DIV) && (cur.action >= ACT_ADD);
  assign sum = first + second;
  assign dif = first - second;
  assign eq  = (first == second);
  assign lt  = $signed(first) < $signed(second);

  always_comb begin
    case (cur.action)
      ACT_JE:  cond = eq;
      ACT_JNE: cond = !eq;
      ACT_JA:  cond = !lt && !eq;
      ACT_JAE: cond = !lt;
      ACT_JB:  cond = lt;
      ACT_JBE: cond = lt || eq;
      default: cond = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_req.action == ACT_POP || q_req.action == ACT_OUT) begin
            state_next = (cnt != '0) ? ST_RD1 : ST_RESULT;
          end else if (q_req.action >= ACT_ADD && q_req.action != ACT_OUT &&
                       q_req.action != ACT_JMP && q_req.action <= ACT_JBE) begin
            state_next = (cnt >= CW'(2)) ? ST_RD1 : ST_RESULT;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_RD1: state_next = (cur.action == ACT_POP || cur.action == ACT_OUT) ?
                           ST_EXEC : ST_RD2;
      ST_RD2: state_next = ST_EXEC;
      ST_EXEC: state_next = (cur.action == ACT_MUL || cur.action == ACT_DIV) ?
                            ST_ARITH : ST_RESULT;
      ST_ARITH: begin
        if ((cur.action == ACT_MUL && mstep == 3'd4) ||
            (cur.action == ACT_DIV && (div_done || second == '0))) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    out_valid = (state == ST_RESULT);
    raddr     = AW'(cnt - CW'(1));
    if (state == ST_RD1) raddr = AW'(cnt - CW'(2));
    div_start = (state == ST_EXEC) && (cur.action == ACT_DIV) && (second != '0);
    we    = (state == ST_IDLE) && q_valid && (q_req.action == ACT_PUSH) &&
            (cnt < CW'(StackDepth));
    waddr = AW'(cnt);
    wdata = q_req.operand;
    if (state == ST_ARITH && state_next == ST_RESULT) begin
      we = 1'b1; wdata = res_val;
    end else if (state == ST_EXEC && is_arith &&
                 !(cur.action == ACT_MUL || cur.action == ACT_DIV)) begin
      we = 1'b1; wdata = res_val;
    end
  end

  always_comb begin
    mag_res = {phh[31:0], 32'd0} + {32'd0, pll[63:32]} + plh + phl;
    case (cur.action)
      ACT_ADD: res_val = (first[DataW-1] == second[DataW-1] &&
                          sum[DataW-1] != first[DataW-1]) ?
                         apply_sign('0, first[DataW-1], 1'b1) : sum;
      ACT_SUB: res_val = (first[DataW-1] != second[DataW-1] &&
                          dif[DataW-1] != first[DataW-1]) ?
                         apply_sign('0, first[DataW-1], 1'b1) : dif;
      ACT_MUL: res_val = apply_sign(mag_res, sat_neg, mul_over);
      ACT_DIV: begin
        if (second == '0) res_val = (first == '0) ? '0 :
                                    apply_sign('0, first[DataW-1], 1'b1);
        else res_val = apply_sign(div_q, sat_neg, div_over);
      end
      default: res_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur          <= q_req;
      ok           <= 1'b0;
      popped_value <= '0;
      jump_taken   <= 1'b0;
      jump_target  <= '0;
      if (q_req.action == ACT_PUSH) ok <= (cnt < CW'(StackDepth));
      if (q_req.action == ACT_JMP && q_req.target_ok) begin
        ok <= 1'b1; jump_taken <= 1'b1; jump_target <= q_req.operand[PlenW-1:0];
      end
    end
    if (state == ST_RD1) first <= rdata;
    if (state == ST_RD2) second <= rdata;
    if (state == ST_EXEC) begin
      ma      <= mag(first);
      mb      <= mag(second);
      sat_neg <= first[DataW-1] ^ second[DataW-1];
      mstep   <= '0;
      if (cur.action == ACT_POP || cur.action == ACT_OUT) begin
        ok <= 1'b1; popped_value <= first;
      end else if (is_arith) begin
        ok <= 1'b1;
      end else if (!cond) begin
        ok <= 1'b1;
      end else if (cur.target_ok) begin
        ok <= 1'b1; jump_taken <= 1'b1; jump_target <= cur.operand[PlenW-1:0];
      end
    end
    if (state == ST_ARITH) begin
      mstep <= mstep + 3'd1;
      if (mstep == 3'd1) begin
        pll <= ma[31:0] * mb[31:0];
        plh <= ma[31:0] * mb[63:32];
      end
      if (mstep == 3'd2) begin
        phl <= ma[63:32] * mb[31:0];
        phh <= ma[63:32] * mb[63:32];
      end
      if (mstep == 3'd3) begin
        // carry check of the upper half
        mul_over <= (phh[63:32] != '0) ||
                    (({32'd0, phh[31:0]} + {32'd0, plh[63:32]} + {32'd0, phl[63:32]} +
                      {32'd0, 32'(({32'd0, pll[63:32]} + {32'd0, plh[31:0]} +
                                    {32'd0, phl[31:0]}) >> 32)}) >> 32 != '0);
      end
    end
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (we && state == ST_IDLE) cnt <= cnt + CW'(1);
      if (state == ST_IDLE && q_valid && q_req.action >= ACT_ADD &&
          q_req.action != ACT_OUT && q_req.action != ACT_JMP &&
          q_req.action <= ACT_JBE && cnt < CW'(2)) cnt <= '0;
      if (state == ST_RD1 && (cur.action == ACT_POP || cur.action == ACT_OUT))
        cnt <= cnt - CW'(1);
      if (state == ST_RD2) cnt <= cnt - CW'(2);
      if (we && state != ST_IDLE) cnt <= cnt + CW'(1);
    end
  end
endmodule
